### sv/tc_pkg.sv
// Package: shared constants, opcodes, controller states and control structs for the text console.
`default_nettype none
package tc_pkg;

	localparam int FRAME_PIXELS     = 76800;
	localparam int FRAME_WORDS      = FRAME_PIXELS / 32;
	localparam int FRAME_AW         = $clog2(FRAME_WORDS);
	localparam int ROW_WORDS        = 10;
	localparam int FRAME_ROWS       = 240;
	localparam int SCROLL_WORDS     = 8 * ROW_WORDS;
	localparam int KEEP_WORDS       = FRAME_WORDS - SCROLL_WORDS;
	localparam int FONT_DEPTH       = 256;
	localparam int FONT_AW          = $clog2(FONT_DEPTH);
	localparam int DEF_TEXT_COLUMNS = 40;
	localparam int DEF_SCROLL_LINE  = 28;

	localparam logic [7:0] CODE_NEWLINE = 8'd10;
	localparam logic [7:0] CODE_TAB     = 8'd9;
	localparam logic [7:0] CODE_SPACE   = 8'd32;

	typedef enum logic [1:0] {
		OP_PUT  = 2'd0,
		OP_LOAD = 2'd1,
		OP_READ = 2'd2,
		OP_NONE = 2'd3
	} tc_op_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOAD,
		ST_READ,
		ST_FONT,
		ST_BLIT_RD,
		ST_BLIT_WR,
		ST_ADVANCE,
		ST_NEWLINE,
		ST_SCR_CP,
		ST_SCR_DRAIN,
		ST_SCR_CLR,
		ST_RESULT
	} tc_state_t;

	typedef struct packed {
		logic cap_in;
		logic clr_wr;
		logic cnt_zero;
		logic cnt_inc;
		logic font_wr;
		logic font_rd;
		logic blit_rd;
		logic blit_wr;
		logic col_adv;
		logic new_line;
		logic scr_rd;
		logic scr_clr_wr;
		logic rd_issue;
		logic out_load;
	} tc_cmd_t;

	typedef struct packed {
		tc_op_t in_op;
		logic   in_newline;
		logic   cnt_end;
		logic   cnt_cp_last;
		logic   row_last;
		logic   col_wrap;
		logic   line_wrap;
		logic   out_free;
	} tc_sts_t;

endpackage
`default_nettype wire

### sv/tc_ram.sv
// Generic single-write, single-read RAM with registered, enabled read.
`default_nettype none
module tc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

### sv/tc_ctrl.sv
// Controller state machine: sequences clear, glyph load, read, blit, newline and scroll.
`default_nettype none
module tc_ctrl import tc_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output logic         in_ready,
	input  wire tc_sts_t sts,
	output tc_cmd_t      cmd
);

	tc_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (sts.cnt_end) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) begin
					case (sts.in_op)
						OP_PUT:  state_d = sts.in_newline ? ST_NEWLINE : ST_FONT;
						OP_LOAD: state_d = ST_LOAD;
						OP_READ: state_d = ST_READ;
						default: state_d = ST_RESULT;
					endcase
				end
			end
			ST_LOAD:    state_d = ST_RESULT;
			ST_READ:    state_d = ST_RESULT;
			ST_FONT:    state_d = ST_BLIT_RD;
			ST_BLIT_RD: state_d = ST_BLIT_WR;
			ST_BLIT_WR: begin
				state_d = sts.row_last ? ST_ADVANCE : ST_BLIT_RD;
			end
			ST_ADVANCE: begin
				state_d = sts.col_wrap ? ST_NEWLINE : ST_RESULT;
			end
			ST_NEWLINE: begin
				state_d = sts.line_wrap ? ST_SCR_CP : ST_RESULT;
			end
			ST_SCR_CP: begin
				if (sts.cnt_cp_last) state_d = ST_SCR_DRAIN;
			end
			ST_SCR_DRAIN: state_d = ST_SCR_CLR;
			ST_SCR_CLR: begin
				if (sts.cnt_end) state_d = ST_RESULT;
			end
			ST_RESULT: begin
				if (sts.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr_wr  = 1'b1;
				cmd.cnt_inc = 1'b1;
			end
			ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.cap_in = in_valid;
			end
			ST_LOAD:    cmd.font_wr = 1'b1;
			ST_READ:    cmd.rd_issue = 1'b1;
			ST_FONT:    cmd.font_rd = 1'b1;
			ST_BLIT_RD: cmd.blit_rd = 1'b1;
			ST_BLIT_WR: cmd.blit_wr = 1'b1;
			ST_ADVANCE: cmd.col_adv = 1'b1;
			ST_NEWLINE: begin
				cmd.new_line = 1'b1;
				cmd.cnt_zero = sts.line_wrap;
			end
			ST_SCR_CP: begin
				cmd.scr_rd  = 1'b1;
				cmd.cnt_inc = 1'b1;
			end
			ST_SCR_DRAIN: begin
			end
			ST_SCR_CLR: begin
				cmd.scr_clr_wr = 1'b1;
				cmd.cnt_inc    = 1'b1;
			end
			ST_RESULT:  cmd.out_load = sts.out_free;
			default: begin
			end
		endcase
	end

endmodule
`default_nettype wire

### sv/tc_dp.sv
// Datapath: input registers, cursor, sweep counter, font and frame memories, result register.
`default_nettype none
module tc_dp import tc_pkg::*; #(
	parameter int TEXT_COLUMNS = DEF_TEXT_COLUMNS,
	parameter int SCROLL_LINE  = DEF_SCROLL_LINE
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire tc_cmd_t     cmd,
	output tc_sts_t          sts,
	input  wire logic [1:0]  operation,
	input  wire logic [7:0]  char_code,
	input  wire logic [63:0] glyph_bits,
	input  wire logic [7:0]  pixel_row,
	input  wire logic [3:0]  word_index,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [31:0]      read_data,
	output logic [5:0]       cursor_column,
	output logic [4:0]       cursor_line
);

	tc_op_t        op_q;
	logic [7:0]    code_q;
	logic [63:0]   glyph_q;
	logic [7:0]    prow_q;
	logic [3:0]    word_q;

	logic [5:0]    col_q;
	logic [4:0]    line_q;
	logic [2:0]    row_q;
	logic [FRAME_AW-1:0] cnt_q;

	logic                cp_wr_s1;
	logic [FRAME_AW-1:0] cp_addr_s1;

	logic        out_valid_q;
	logic [31:0] read_data_q;
	logic [5:0]  col_out_q;
	logic [4:0]  line_out_q;

	logic                fr_we, fr_re;
	logic [FRAME_AW-1:0] fr_waddr, fr_raddr;
	logic [31:0]         fr_wdata, fr_rdata;
	logic                fn_we;
	logic [FONT_AW-1:0]  fn_waddr, fn_raddr;
	logic [63:0]         fn_wdata, fn_rdata;

	logic [FRAME_AW-1:0] blit_addr, read_addr, blit_prow;
	logic [FRAME_AW-1:0] read_prow;
	logic [7:0]          glyph_byte;
	logic [31:0]         merged;
	logic                rd_ok;
	logic [7:0]          put_code;

	always_ff @(posedge clk) begin
		if (cmd.cap_in) begin
			op_q    <= tc_op_t'(operation);
			code_q  <= char_code;
			glyph_q <= glyph_bits;
			prow_q  <= pixel_row;
			word_q  <= word_index;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			line_q   <= '0;
			row_q    <= '0;
			cnt_q    <= '0;
			cp_wr_s1 <= 1'b0;
		end else begin
			if (cmd.col_adv) begin
				col_q <= col_q + 6'd1;
			end
			if (cmd.new_line) begin
				col_q <= '0;
				if (!sts.line_wrap) line_q <= line_q + 5'd1;
			end
			if (cmd.blit_wr) begin
				row_q <= row_q + 3'd1;
			end
			if (cmd.cnt_zero) begin
				cnt_q <= '0;
			end else if (cmd.cnt_inc) begin
				cnt_q <= cnt_q + FRAME_AW'(1);
			end
			cp_wr_s1 <= cmd.scr_rd;
		end
	end

	always_ff @(posedge clk) begin
		cp_addr_s1 <= cnt_q;
	end

	// pixel row * 10 as shift-add
	assign blit_prow = FRAME_AW'({line_q, row_q});
	assign blit_addr = (blit_prow << 3) + (blit_prow << 1) + FRAME_AW'(col_q[5:2]);
	assign read_prow = FRAME_AW'(prow_q);
	assign read_addr = (read_prow << 3) + (read_prow << 1) + FRAME_AW'(word_q);
	assign rd_ok     = (op_q == OP_READ) && (prow_q < 8'(FRAME_ROWS))
	                   && (word_q < 4'(ROW_WORDS));

	assign put_code   = (code_q == CODE_TAB) ? CODE_SPACE : code_q;
	assign glyph_byte = fn_rdata[{~row_q, 3'b000} +: 8];

	always_comb begin
		merged = fr_rdata;
		merged[{~col_q[1:0], 3'b000} +: 8] = glyph_byte;
	end

	always_comb begin
		fr_we    = 1'b0;
		fr_waddr = cnt_q;
		fr_wdata = '0;
		if (cmd.clr_wr || cmd.scr_clr_wr) begin
			fr_we = 1'b1;
		end else if (cmd.blit_wr) begin
			fr_we    = 1'b1;
			fr_waddr = blit_addr;
			fr_wdata = merged;
		end else if (cp_wr_s1) begin
			fr_we    = 1'b1;
			fr_waddr = cp_addr_s1;
			fr_wdata = fr_rdata;
		end
	end

	always_comb begin
		fr_re    = 1'b0;
		fr_raddr = blit_addr;
		if (cmd.blit_rd) begin
			fr_re = 1'b1;
		end else if (cmd.rd_issue) begin
			fr_re    = rd_ok;
			fr_raddr = read_addr;
		end else if (cmd.scr_rd) begin
			fr_re    = 1'b1;
			fr_raddr = cnt_q + FRAME_AW'(SCROLL_WORDS);
		end
	end

	always_comb begin
		fn_we    = 1'b0;
		fn_waddr = code_q;
		fn_wdata = glyph_q;
		if (cmd.clr_wr) begin
			fn_we    = (cnt_q < FRAME_AW'(FONT_DEPTH));
			fn_waddr = cnt_q[FONT_AW-1:0];
			fn_wdata = '0;
		end else if (cmd.font_wr) begin
			fn_we = 1'b1;
		end
	end

	assign fn_raddr = put_code;

	tc_ram #(
		.WIDTH (32),
		.DEPTH (FRAME_WORDS)
	) u_frame (
		.clk   (clk),
		.we    (fr_we),
		.waddr (fr_waddr),
		.wdata (fr_wdata),
		.re    (fr_re),
		.raddr (fr_raddr),
		.rdata (fr_rdata)
	);

	tc_ram #(
		.WIDTH (64),
		.DEPTH (FONT_DEPTH)
	) u_font (
		.clk   (clk),
		.we    (fn_we),
		.waddr (fn_waddr),
		.wdata (fn_wdata),
		.re    (cmd.font_rd),
		.raddr (fn_raddr),
		.rdata (fn_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			read_data_q <= rd_ok ? fr_rdata : 32'd0;
			col_out_q   <= col_q;
			line_out_q  <= line_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign read_data     = read_data_q;
	assign cursor_column = col_out_q;
	assign cursor_line   = line_out_q;

	always_comb begin
		sts             = '0;
		sts.in_op       = tc_op_t'(operation);
		sts.in_newline  = (char_code == CODE_NEWLINE);
		sts.cnt_end     = (cnt_q == FRAME_AW'(FRAME_WORDS - 1));
		sts.cnt_cp_last = (cnt_q == FRAME_AW'(KEEP_WORDS - 1));
		sts.row_last    = (row_q == 3'd7);
		sts.col_wrap    = ({1'b0, col_q} + 7'd1) >= 7'(TEXT_COLUMNS);
		sts.line_wrap   = ({1'b0, line_q} + 6'd1) >= 6'(SCROLL_LINE);
		sts.out_free    = !out_valid_q || out_ready;
	end

endmodule
`default_nettype wire

### sv/text_console_renderer.sv
// Top level of the 8x8-font text console rendering into a 320x240 one-bit frame.
// Input channel (in_valid/in_ready) takes one item: put character, load glyph,
// or read one 32-pixel frame word. Output channel (out_valid/out_ready) returns
// one item per input: read_data (zero unless a read) and the cursor afterwards.
// Items are handled one at a time by a controller/datapath pair around two
// single-port-write RAMs (frame 2400x32, font 256x64).
// A printable character takes a font read, then a read-modify-write of 8 frame
// words through the one frame read port and one write port, then a cursor
// advance and, if the column wraps, a newline. Load glyph, read and newline each
// pass through their own state; an unused code goes straight to the result.
// After the result is registered the controller accepts the next item.
// A scroll copies 2320 words one per cycle, passes a drain state, then
// clears 80 words, all through the frame RAM ports.
// After reset a clearing pass over all 2400 frame words zeroes the frame and
// font RAMs; in_ready stays low until it ends. Cursor resets to column 0, line 0.
// The result sits in an output register; the next item is accepted while it
// waits, but that item's result is held back until the receiver takes the
// previous one.
`default_nettype none
module text_console_renderer import tc_pkg::*; #(
	parameter int TEXT_COLUMNS = DEF_TEXT_COLUMNS,
	parameter int SCROLL_LINE  = DEF_SCROLL_LINE
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  operation,
	input  wire logic [7:0]  char_code,
	input  wire logic [63:0] glyph_bits,
	input  wire logic [7:0]  pixel_row,
	input  wire logic [3:0]  word_index,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [31:0]      read_data,
	output logic [5:0]       cursor_column,
	output logic [4:0]       cursor_line
);

	tc_cmd_t cmd;
	tc_sts_t sts;

	tc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	tc_dp #(
		.TEXT_COLUMNS (TEXT_COLUMNS),
		.SCROLL_LINE  (SCROLL_LINE)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.operation     (operation),
		.char_code     (char_code),
		.glyph_bits    (glyph_bits),
		.pixel_row     (pixel_row),
		.word_index    (word_index),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.read_data     (read_data),
		.cursor_column (cursor_column),
		.cursor_line   (cursor_line)
	);

endmodule
`default_nettype wire
